### rtl/frsp_pkg.sv
`timescale 1ns / 1ps

package frsp_pkg;

    localparam logic [7:0]  CH_TAB    = 8'h09;
    localparam logic [7:0]  CH_LF     = 8'h0A;
    localparam logic [7:0]  CH_VT     = 8'h0B;
    localparam logic [7:0]  CH_FF     = 8'h0C;
    localparam logic [7:0]  CH_CR     = 8'h0D;
    localparam logic [7:0]  CH_SPACE  = 8'h20;
    localparam logic [7:0]  CH_COMMA  = 8'h2C;
    localparam logic [7:0]  CH_HYPHEN = 8'h2D;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_NINE   = 8'h39;
    localparam logic [7:0]  CH_NEL    = 8'h85;
    localparam logic [7:0]  CH_NBSP   = 8'hA0;

    localparam logic [30:0] SAT_MAX     = 31'h7fff_ffff;
    localparam logic [30:0] DELAY_FLOOR = 31'd10;

    // Number slots inside a line.
    localparam logic [2:0]  NUM_START = 3'd0;
    localparam logic [2:0]  NUM_END   = 3'd1;
    localparam logic [2:0]  NUM_DELAY = 3'd2;
    localparam logic [2:0]  BAD_OFFS  = 3'd3;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_FIELD_COUNT = 3'd1,
        ST_BAD_FRAME   = 3'd2,
        ST_BAD_START   = 3'd3,
        ST_BAD_END     = 3'd4,
        ST_BAD_DELAY   = 3'd5
    } t_status;

    typedef struct packed {
        logic        nonempty;
        logic        has_text;
        logic        space_pending;
        logic [1:0]  part_count;
        logic        part_open;
        logic        hyphen_seen;
        logic [30:0] start_accum;
        logic [30:0] end_accum;
        logic [30:0] delay_accum;
        logic [5:0]  digit_flags;
    } t_line;

    typedef struct packed {
        t_status     status;
        logic [15:0] first_frame;
        logic [15:0] final_frame;
        logic [30:0] delay_value;
    } t_result;

    function automatic logic is_ws(logic [7:0] c);
        return c inside {CH_TAB, CH_VT, CH_FF, CH_SPACE, CH_NEL, CH_NBSP};
    endfunction

    // One character of a line after whitespace collapsing.
    function automatic t_line feed_char(t_line s, logic [7:0] c);
        t_line       r;
        logic [2:0]  w;
        logic        take;
        logic [30:0] a;
        logic [34:0] v;
        logic [7:0]  d;
        r    = s;
        w    = NUM_START;
        take = 1'b0;
        a    = '0;
        v    = '0;
        d    = c - CH_ZERO;
        if (c == CH_COMMA) begin
            r.part_open = 1'b0;
        end else begin
            if (!r.part_open) begin
                r.part_open = 1'b1;
                if (r.part_count != 2'd3) begin
                    r.part_count = r.part_count + 2'd1;
                end
            end
            if (r.part_count == 2'd1) begin
                if (c == CH_HYPHEN && !r.hyphen_seen) begin
                    r.hyphen_seen = 1'b1;
                end else begin
                    take = 1'b1;
                    w    = r.hyphen_seen ? NUM_END : NUM_START;
                end
            end else if (r.part_count == 2'd2) begin
                take = 1'b1;
                w    = NUM_DELAY;
            end
        end
        if (take) begin
            r.digit_flags[w] = 1'b1;
            if (c inside {[CH_ZERO:CH_NINE]}) begin
                case (w)
                    NUM_START: a = r.start_accum;
                    NUM_END:   a = r.end_accum;
                    default:   a = r.delay_accum;
                endcase
                v = {4'b0, a} * 35'd10 + {27'b0, d};
                if (v > {4'b0, SAT_MAX}) begin
                    a = SAT_MAX;
                end else begin
                    a = v[30:0];
                end
                case (w)
                    NUM_START: r.start_accum = a;
                    NUM_END:   r.end_accum   = a;
                    default:   r.delay_accum = a;
                endcase
            end else begin
                r.digit_flags[w + BAD_OFFS] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

### rtl/frsp_line_finish.sv
`timescale 1ns / 1ps

module frsp_line_finish (
    input  frsp_pkg::t_line   i_line,
    input  logic [15:0]       i_max_frame,
    output frsp_pkg::t_result o_result
);

    logic        start_ok;
    logic        end_ok;
    logic        delay_ok;
    logic [15:0] start_clamped;
    logic [15:0] end_clamped;

    function automatic logic [15:0] clamp_frame(logic [30:0] v, logic [15:0] m);
        logic [15:0] c;
        c = (v > {15'b0, m}) ? m : v[15:0];
        return (c == 16'd0) ? 16'd0 : c - 16'd1;
    endfunction

    assign start_ok = i_line.digit_flags[frsp_pkg::NUM_START]
                      && !i_line.digit_flags[frsp_pkg::NUM_START + frsp_pkg::BAD_OFFS];
    assign end_ok   = i_line.digit_flags[frsp_pkg::NUM_END]
                      && !i_line.digit_flags[frsp_pkg::NUM_END + frsp_pkg::BAD_OFFS];
    assign delay_ok = i_line.digit_flags[frsp_pkg::NUM_DELAY]
                      && !i_line.digit_flags[frsp_pkg::NUM_DELAY + frsp_pkg::BAD_OFFS];

    assign start_clamped = clamp_frame(i_line.start_accum, i_max_frame);
    assign end_clamped   = clamp_frame(i_line.end_accum, i_max_frame);

    always_comb begin
        o_result = '0;
        if (i_line.part_count != 2'd2) begin
            o_result.status = frsp_pkg::ST_FIELD_COUNT;
        end else if (!i_line.hyphen_seen && !start_ok) begin
            o_result.status = frsp_pkg::ST_BAD_FRAME;
        end else if (i_line.hyphen_seen && !start_ok) begin
            o_result.status = frsp_pkg::ST_BAD_START;
        end else if (i_line.hyphen_seen && !end_ok) begin
            o_result.status = frsp_pkg::ST_BAD_END;
        end else if (!delay_ok) begin
            o_result.status = frsp_pkg::ST_BAD_DELAY;
        end else begin
            o_result.status      = frsp_pkg::ST_OK;
            o_result.first_frame = start_clamped;
            o_result.final_frame = i_line.hyphen_seen ? end_clamped : start_clamped;
            o_result.delay_value = (i_line.delay_accum < frsp_pkg::DELAY_FLOOR)
                                   ? frsp_pkg::DELAY_FLOOR : i_line.delay_accum;
        end
    end

endmodule

### rtl/frame_range_script_parser_unit.sv
`timescale 1ns / 1ps

// Animation script parser. Script bytes arrive one word per cycle on the
// input channel (i_in_valid / o_in_stall, payload i_ch and i_end_of_script).
// CR or LF closes a line; i_end_of_script closes an unterminated last line.
// Every nonempty line, even whitespace only, gives one result word on the
// output channel (o_out_valid / i_out_stall): a status code and, for a good
// line, the zero-based frame range and the delay. Empty lines give nothing.
// max_frame is written through i_cfg_valid / i_cfg_data; o_cfg_ready is
// always high, and writes are expected only while the parser is idle.
// A byte accepted into the input register (r_ch) is processed from there
// while the output is free; a finished line's result word is then
// registered in the result register (r_result) and held until taken.
// Throughput: one byte per cycle while o_in_stall is low, set by the
// combinational line update (one multiply by ten and add per byte) between
// the input and result registers.
// While the output word is held by i_out_stall, the parser holds its
// current byte and raises o_in_stall; nothing is lost or repeated.
// Synchronous reset (i_rst_n low) empties both registers, clears the line
// state and sets max_frame to 1.

module frame_range_script_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_script,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_first_frame,
    output logic [15:0] o_final_frame,
    output logic [30:0] o_delay_value,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic              r_in_valid;
    logic [7:0]        r_ch;
    logic              r_eos;
    logic [15:0]       r_max_frame;
    frsp_pkg::t_line   r_line;
    frsp_pkg::t_line   n_line;
    logic              r_out_valid;
    frsp_pkg::t_result r_result;

    frsp_pkg::t_line   stepped;
    frsp_pkg::t_line   fin_src;
    frsp_pkg::t_result fin_result;
    logic              out_free;
    logic              advance;
    logic              is_eol;
    logic              line_end;
    logic              do_finish;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign o_cfg_ready = 1'b1;

    assign is_eol   = (r_ch == frsp_pkg::CH_CR) || (r_ch == frsp_pkg::CH_LF);
    assign line_end = is_eol || r_eos;

    always_comb begin
        stepped = r_line;
        if (!is_eol) begin
            stepped.nonempty = 1'b1;
            if (frsp_pkg::is_ws(r_ch)) begin
                if (r_line.has_text) begin
                    stepped.space_pending = 1'b1;
                end
            end else begin
                // A collapsed space is fed ahead of the byte that follows it.
                if (r_line.space_pending) begin
                    stepped = frsp_pkg::feed_char(stepped, frsp_pkg::CH_SPACE);
                    stepped.space_pending = 1'b0;
                end
                stepped = frsp_pkg::feed_char(stepped, r_ch);
                stepped.has_text = 1'b1;
            end
        end
    end

    // On a line break the line so far is finished; at end of script with no
    // break, the line including this byte is.
    assign fin_src   = is_eol ? r_line : stepped;
    assign do_finish = line_end && fin_src.nonempty;
    assign n_line    = line_end ? '0 : stepped;

    frsp_line_finish u_finish (
        .i_line      (fin_src),
        .i_max_frame (r_max_frame),
        .o_result    (fin_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_line      <= '0;
            r_max_frame <= 16'd1;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_line <= n_line;
            end
            if (out_free) begin
                r_out_valid <= advance && do_finish;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_frame <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_ch  <= i_ch;
            r_eos <= i_end_of_script;
        end
        if (advance && do_finish) begin
            r_result <= fin_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_result.status;
    assign o_first_frame = r_result.first_frame;
    assign o_final_frame = r_result.final_frame;
    assign o_delay_value = r_result.delay_value;

`ifndef SYNTHESIS
    a_err_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != frsp_pkg::ST_OK) |->
        (o_first_frame == 16'd0 && o_final_frame == 16'd0 && o_delay_value == 31'd0))
        else $error("error result carries a nonzero payload");

    a_delay_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == frsp_pkg::ST_OK) |->
        (o_delay_value >= frsp_pkg::DELAY_FLOOR))
        else $error("delay below floor");

    a_frame_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == frsp_pkg::ST_OK && r_max_frame != 16'd0) |->
        (o_first_frame < r_max_frame && o_final_frame < r_max_frame))
        else $error("frame beyond max_frame");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= frsp_pkg::ST_BAD_DELAY))
        else $error("status code out of range");

    a_line_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && line_end) |=> (!r_line.nonempty && r_line.part_count == 2'd0))
        else $error("line state not cleared at end of line");
`endif

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_ch;
    logic        i_end_of_script;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [15:0] o_first_frame;
    logic [15:0] o_final_frame;
    logic [30:0] o_delay_value;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    frame_range_script_parser_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_ch            (i_ch),
        .i_end_of_script (i_end_of_script),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_first_frame   (o_first_frame),
        .o_final_frame   (o_final_frame),
        .o_delay_value   (o_delay_value),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // Line parser predictor state.
    logic [15:0] frame_limit;
    logic        ln_nonempty;
    logic        ln_has_text;
    logic        ln_space_wait;
    logic [1:0]  ln_parts;
    logic        ln_in_part;
    logic        ln_dash;
    logic [30:0] num_val  [3];
    logic        num_seen [3];
    logic        num_bad  [3];

    frsp_pkg::t_result expected_lines[$];
    logic [7:0]        line_buf[$];

    int errors;
    int bytes_sent;
    int results_seen;
    int good_lines;
    int cfg_writes;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_cycles;

    function automatic void line_reset_model();
        ln_nonempty   = 1'b0;
        ln_has_text   = 1'b0;
        ln_space_wait = 1'b0;
        ln_parts      = 2'd0;
        ln_in_part    = 1'b0;
        ln_dash       = 1'b0;
        for (int k = 0; k < 3; k++) begin
            num_val[k]  = '0;
            num_seen[k] = 1'b0;
            num_bad[k]  = 1'b0;
        end
    endfunction

    function automatic void number_feed(logic [1:0] slot, logic [7:0] c);
        longint unsigned v;
        num_seen[slot] = 1'b1;
        if (c >= frsp_pkg::CH_ZERO && c <= frsp_pkg::CH_NINE) begin
            v = longint'(num_val[slot]) * 10 + longint'(c - frsp_pkg::CH_ZERO);
            num_val[slot] = (v > frsp_pkg::SAT_MAX) ? frsp_pkg::SAT_MAX : v[30:0];
        end else begin
            num_bad[slot] = 1'b1;
        end
    endfunction

    function automatic void part_feed(logic [7:0] c);
        if (c == frsp_pkg::CH_COMMA) begin
            ln_in_part = 1'b0;
            return;
        end
        if (!ln_in_part) begin
            ln_in_part = 1'b1;
            if (ln_parts != 2'd3) ln_parts = ln_parts + 2'd1;
        end
        if (ln_parts == 2'd1) begin
            // Only the first hyphen of the frame part splits the range.
            if (c == frsp_pkg::CH_HYPHEN && !ln_dash) ln_dash = 1'b1;
            else number_feed(ln_dash ? 2'(frsp_pkg::NUM_END) : 2'(frsp_pkg::NUM_START), c);
        end else if (ln_parts == 2'd2) begin
            number_feed(2'(frsp_pkg::NUM_DELAY), c);
        end
    endfunction

    function automatic logic number_good(logic [1:0] slot);
        return num_seen[slot] && !num_bad[slot];
    endfunction

    function automatic logic [15:0] frame_index(logic [30:0] v);
        logic [30:0] lim;
        lim = {15'd0, frame_limit};
        if (v > lim) v = lim;
        if (v < 31'd1) v = 31'd1;
        v = v - 31'd1;
        return v[15:0];
    endfunction

    function automatic logic line_close();
        frsp_pkg::t_result r;
        r.status      = frsp_pkg::ST_OK;
        r.first_frame = '0;
        r.final_frame = '0;
        r.delay_value = '0;
        if (!ln_nonempty) begin
            line_reset_model();
            return 1'b0;
        end
        if (ln_parts != 2'd2) begin
            r.status = frsp_pkg::ST_FIELD_COUNT;
        end else if (!ln_dash) begin
            if (!number_good(2'(frsp_pkg::NUM_START))) begin
                r.status = frsp_pkg::ST_BAD_FRAME;
            end else begin
                r.first_frame = frame_index(num_val[2'(frsp_pkg::NUM_START)]);
                r.final_frame = r.first_frame;
            end
        end else if (!number_good(2'(frsp_pkg::NUM_START))) begin
            r.status = frsp_pkg::ST_BAD_START;
        end else if (!number_good(2'(frsp_pkg::NUM_END))) begin
            r.status = frsp_pkg::ST_BAD_END;
        end else begin
            r.first_frame = frame_index(num_val[2'(frsp_pkg::NUM_START)]);
            r.final_frame = frame_index(num_val[2'(frsp_pkg::NUM_END)]);
        end
        if (r.status == frsp_pkg::ST_OK) begin
            if (!number_good(2'(frsp_pkg::NUM_DELAY)))
                r.status = frsp_pkg::ST_BAD_DELAY;
            else if (num_val[2'(frsp_pkg::NUM_DELAY)] < frsp_pkg::DELAY_FLOOR)
                r.delay_value = frsp_pkg::DELAY_FLOOR;
            else
                r.delay_value = num_val[2'(frsp_pkg::NUM_DELAY)];
        end
        if (r.status != frsp_pkg::ST_OK) begin
            r.first_frame = '0;
            r.final_frame = '0;
            r.delay_value = '0;
        end else begin
            good_lines++;
        end
        expected_lines.push_back(r);
        line_reset_model();
        return 1'b1;
    endfunction

    function automatic void script_byte_model(logic [7:0] c, logic eos);
        logic produced;
        produced = 1'b0;
        if (c == frsp_pkg::CH_CR || c == frsp_pkg::CH_LF) begin
            produced = line_close();
        end else begin
            ln_nonempty = 1'b1;
            if (c == frsp_pkg::CH_TAB || c == frsp_pkg::CH_VT || c == frsp_pkg::CH_FF ||
                c == frsp_pkg::CH_SPACE || c == frsp_pkg::CH_NEL ||
                c == frsp_pkg::CH_NBSP) begin
                if (ln_has_text) ln_space_wait = 1'b1;
            end else begin
                // A collapsed whitespace run only counts once text follows it.
                if (ln_space_wait) begin
                    part_feed(frsp_pkg::CH_SPACE);
                    ln_space_wait = 1'b0;
                end
                part_feed(c);
                ln_has_text = 1'b1;
            end
        end
        if (eos && !produced) void'(line_close());
        else if (eos) line_reset_model();
    endfunction

    // Clock, stall and timeout processes.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                i_out_stall = 1'b1;
                hold_off_cycles--;
            end else begin
                i_out_stall = ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    initial begin
        #3_000_000;
        $display("[frame_range_script_parser_unit] ERROR");
        $finish;
    end

    always @(posedge i_clk) begin : result_check
        frsp_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_lines.size() == 0) begin
                $error("result word with nothing expected: status %0d", o_status);
                errors++;
            end else begin
                want = expected_lines.pop_front();
                results_seen++;
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    errors++;
                end
                if (o_first_frame !== want.first_frame) begin
                    $error("first_frame: expected %0d, got %0d", want.first_frame,
                           o_first_frame);
                    errors++;
                end
                if (o_final_frame !== want.final_frame) begin
                    $error("final_frame: expected %0d, got %0d", want.final_frame,
                           o_final_frame);
                    errors++;
                end
                if (o_delay_value !== want.delay_value) begin
                    $error("delay_value: expected %0d, got %0d", want.delay_value,
                           o_delay_value);
                    errors++;
                end
            end
        end
    end

    // Offers one script word; returns once it has been taken.
    task automatic send_byte(input logic [7:0] c, input logic eos);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_ch            = c;
        i_end_of_script = eos;
        do @(posedge i_clk); while (o_in_stall);
        script_byte_model(c, eos);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k], 1'b0);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_lines.size() != 0) @(posedge i_clk);
        // Words that end no line may still be in the pipeline.
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max_frame(input logic [15:0] v);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        frame_limit = v;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Script line generation.
    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 5))
            0:       return frsp_pkg::CH_TAB;
            1:       return frsp_pkg::CH_VT;
            2:       return frsp_pkg::CH_FF;
            3:       return frsp_pkg::CH_NEL;
            4:       return frsp_pkg::CH_NBSP;
            default: return frsp_pkg::CH_SPACE;
        endcase
    endfunction

    function automatic void push_pad();
        if ($urandom_range(0, 99) < 30)
            repeat ($urandom_range(1, 3)) line_buf.push_back(pick_ws());
    endfunction

    function automatic void push_number();
        int r;
        int n;
        r = $urandom_range(0, 99);
        // Mostly short numbers; a few long enough to saturate.
        n = (r < 60) ? $urandom_range(1, 3) : (r < 85) ? $urandom_range(4, 5)
                     : $urandom_range(9, 12);
        repeat (n) line_buf.push_back(frsp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void push_maybe_comma();
        if ($urandom_range(0, 99) < 15) line_buf.push_back(frsp_pkg::CH_COMMA);
    endfunction

    function automatic void build_good_line();
        line_buf.delete();
        push_pad();
        push_maybe_comma();
        push_number();
        if ($urandom_range(0, 1) == 1) begin
            line_buf.push_back(frsp_pkg::CH_HYPHEN);
            push_number();
        end
        line_buf.push_back(frsp_pkg::CH_COMMA);
        push_maybe_comma();
        push_number();
        push_maybe_comma();
        push_pad();
    endfunction

    function automatic void damage_line();
        int pos;
        pos = $urandom_range(0, line_buf.size());
        case ($urandom_range(0, 4))
            0: line_buf.insert(pos, 8'($urandom_range(0, 255)));
            1: line_buf.insert(pos, frsp_pkg::CH_HYPHEN);
            2: line_buf.insert(pos, frsp_pkg::CH_COMMA);
            3: line_buf.insert(pos, pick_ws());
            default: if (line_buf.size() != 0)
                line_buf.delete($urandom_range(0, line_buf.size() - 1));
        endcase
    endfunction

    function automatic void build_line();
        int r;
        r = $urandom_range(0, 99);
        if (r < 72) begin
            build_good_line();
            if (r >= 55) repeat ($urandom_range(1, 2)) damage_line();
        end else begin
            line_buf.delete();
            if (r < 80)
                repeat ($urandom_range(1, 3)) line_buf.push_back(pick_ws());
            else if (r >= 86)
                repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_line(input logic closing);
        int   t;
        logic eos;
        t   = $urandom_range(0, 99);
        eos = closing || t >= 88;
        if (eos) begin
            if (line_buf.size() == 0 || t >= 95) line_buf.push_back(frsp_pkg::CH_LF);
        end else if (t < 50) begin
            line_buf.push_back(frsp_pkg::CH_LF);
        end else if (t < 75) begin
            line_buf.push_back(frsp_pkg::CH_CR);
        end else begin
            line_buf.push_back(frsp_pkg::CH_CR);
            line_buf.push_back(frsp_pkg::CH_LF);
        end
        for (int k = 0; k < line_buf.size(); k++)
            send_byte(line_buf[k], eos && k == line_buf.size() - 1);
    endtask

    // Tests.
    task automatic test_directed_lines();
        write_max_frame(16'd20);
        send_text("3-1,5");
        send_byte(frsp_pkg::CH_CR, 1'b0);
        send_byte(frsp_pkg::CH_NEL, 1'b0);
        send_byte(frsp_pkg::CH_SPACE, 1'b0);
        send_byte(frsp_pkg::CH_LF, 1'b0);
        send_byte(frsp_pkg::CH_LF, 1'b0);
        send_text("7 8,0");
        send_byte(frsp_pkg::CH_LF, 1'b0);
        send_text("1-2-3,9");
        send_byte(frsp_pkg::CH_LF, 1'b1);
    endtask

    task automatic test_random_script(input logic [15:0] limit, input int budget);
        int start;
        wait_idle();
        write_max_frame(limit);
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            build_line();
            send_line(1'b0);
        end
        // Close the phase on a complete line so that the parser is left idle.
        build_good_line();
        send_line(1'b1);
    endtask

    task automatic test_output_hold();
        wait_idle();
        hold_off_cycles = 80;
        repeat (8) begin
            send_text("12,40");
            send_byte(frsp_pkg::CH_LF, 1'b0);
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_ch            = '0;
        i_end_of_script = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        errors          = 0;
        bytes_sent      = 0;
        results_seen    = 0;
        good_lines      = 0;
        cfg_writes      = 0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_off_cycles = 0;
        frame_limit     = 16'd1;
        line_reset_model();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_lines();

        send_idle_pct = 13;
        recv_idle_pct = 59;
        test_random_script(16'd0, 110);
        test_random_script(16'd1, 110);

        send_idle_pct = 59;
        recv_idle_pct = 13;
        test_random_script(16'd9, 110);
        test_random_script(16'($urandom_range(2, 65534)), 110);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_script(16'hFFFF, 110);
        test_output_hold();

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (expected_lines.size() != 0) begin
            $error("%0d expected result words never arrived", expected_lines.size());
            errors++;
        end
        $display("Covered %0d script bytes and %0d result words (%0d good lines),",
                 bytes_sent, results_seen, good_lines);
        $display("over %0d max_frame settings from 0 to 65535, with output hold-off.",
                 cfg_writes);
        if (errors == 0) begin
            $display("[frame_range_script_parser_unit] OK");
        end else begin
            $display("[frame_range_script_parser_unit] ERROR");
        end
        $finish;
    end

endmodule
